FILE: sv/bch_127_t4_codec_unit_defines.svh
// assertion macros for the bch codec unit
// no dependencies; included by the files that carry assertions
`ifndef BCH_127_T4_CODEC_UNIT_DEFINES_SVH
`define BCH_127_T4_CODEC_UNIT_DEFINES_SVH

// same-cycle implication
`define BCH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/bch_pkg.sv
// package for the bch codec unit: field tables, generator taps, codes, types
// no dependencies; used by bch_gf_unit and bch_127_t4_codec_unit
package bch_pkg;

   localparam int DataBits     = 64;
   localparam int ParBits      = 28;
   localparam int ReqTdataBits = 96;
   localparam int RspTdataBits = 104;
   localparam int BchT         = 4;
   localparam int GfN          = 127;

   typedef logic [6:0] gf_type;

   typedef enum logic {
      GF_MUL = 1'b0,
      GF_DIV = 1'b1
   } gf_op_type;

   typedef struct packed {
      gf_op_type op;
      gf_type    a;
      gf_type    b;
   } gf_req_type;

   localparam logic       CMD_ENCODE    = 1'b0;
   localparam logic       CMD_DECODE    = 1'b1;
   localparam logic [1:0] STATUS_CLEAN  = 2'd0;
   localparam logic [1:0] STATUS_FIXED  = 2'd1;
   localparam logic [1:0] STATUS_UNCORR = 2'd2;

   // powers of alpha, entry 127 wraps to one
   function automatic logic [127:0][6:0] build_alog();
      logic [127:0][6:0] t;
      logic [7:0]        x;
      t = '0;
      x = 8'd1;
      for (int i = 0; i < GfN; i++) begin
         t[i] = x[6:0];
         x = {x[6:0], 1'b0};
         if (x[7]) x = x ^ 8'h83;
      end
      t[127] = 7'd1;
      return t;
   endfunction

   localparam logic [127:0][6:0] GF_ALOG = build_alog();

   // discrete logarithms, log of zero reads as zero
   function automatic logic [127:0][6:0] build_log();
      logic [127:0][6:0] t;
      t = '0;
      for (int i = 0; i < GfN; i++) t[GF_ALOG[i]] = 7'(i);
      t[0] = 7'd0;
      return t;
   endfunction

   localparam logic [127:0][6:0] GF_LOG = build_log();

   // shift-and-add field multiply for elaboration only
   function automatic gf_type gf_mul_slow(gf_type a, gf_type b);
      gf_type r;
      gf_type aa;
      r  = '0;
      aa = a;
      for (int i = 0; i < 7; i++) begin
         if (b[i]) r = r ^ aa;
         aa = {aa[5:0], 1'b0} ^ (aa[6] ? 7'h03 : 7'h00);
      end
      return r;
   endfunction

   // generator as product of minimal polynomials of alpha, alpha^3, alpha^5, alpha^7
   function automatic logic [27:0] build_gen();
      logic [127:0]      isroot;
      logic [28:0][6:0]  g;
      logic [27:0]       taps;
      int                r;
      int                deg;
      gf_type            rr;
      isroot = '0;
      g      = '0;
      deg    = 0;
      for (int i = 0; i < BchT; i++) begin
         r = 2 * i + 1;
         for (int j = 0; j < 7; j++) begin
            isroot[r] = 1'b1;
            r = 2 * r;
            if (r >= GfN) r = r - GfN;
         end
      end
      g[0] = 7'd1;
      for (int i = 0; i < GfN; i++) begin
         if (isroot[i] && deg < ParBits) begin
            rr = GF_ALOG[i];
            g[deg + 1] = 7'd1;
            for (int j = deg; j > 0; j--) g[j] = gf_mul_slow(g[j], rr) ^ g[j - 1];
            g[0] = gf_mul_slow(g[0], rr);
            deg = deg + 1;
         end
      end
      for (int j = 0; j < ParBits; j++) taps[j] = (g[j] != 7'd0);
      return taps;
   endfunction

   localparam logic [27:0] GEN_TAPS = build_gen();

   // reduce a sum below 254 modulo 127
   function automatic gf_type gf_mod(logic [7:0] v);
      logic [7:0] w;
      w = v - 8'd127;
      return (v >= 8'd127) ? w[6:0] : v[6:0];
   endfunction

endpackage

FILE: sv/bch_gf_unit.sv
// shared gf(2^7) multiply and divide through log and antilog tables
// depends on bch_pkg
module bch_gf_unit (
   input  bch_pkg::gf_req_type req,
   output bch_pkg::gf_type     res
);
   import bch_pkg::*;

   gf_type     la;
   gf_type     lb;
   logic [7:0] sum;

   // exponent add or subtract, then antilog
   always_comb begin
      la = GF_LOG[req.a];
      lb = GF_LOG[req.b];
      unique case (req.op)
         GF_MUL:  sum = {1'b0, la} + {1'b0, lb};
         GF_DIV:  sum = {1'b0, la} + 8'd127 - {1'b0, lb};
         default: sum = '0;
      endcase
      if (req.a == 7'd0 || req.b == 7'd0) res = '0;
      else res = GF_ALOG[gf_mod(sum)];
   end

endmodule

FILE: sv/bch_127_t4_codec_unit.sv
// top level of the bch(127) t=4 codec: 64 data bits, 28 parity bits
// depends on bch_pkg, bch_gf_unit and bch_127_t4_codec_unit_defines.svh
// encode, and decode of a clean word, respond after the serial parity pass; other decodes
// then run the syndromes, squaring, berlekamp-massey and, for a locator of degree 1 to 4,
// a root search over all 127 positions on the one shared gf multiplier
// one request in flight at a time; synchronous active-high reset clears control only
`include "bch_127_t4_codec_unit_defines.svh"

module bch_127_t4_codec_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // data_word [63:0], ecc_in [91:64], zero [95:92]
   input  logic [bch_pkg::ReqTdataBits-1:0]   req_tdata,
   // cmd [0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // data_out [63:0], ecc_out [91:64], status [93:92], error_count [96:94], zero [103:97]
   output logic [bch_pkg::RspTdataBits-1:0]   rsp_tdata
);
   import bch_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_LFSR   = 13'b0000000000010,
      S_SYN    = 13'b0000000000100,
      S_SQR    = 13'b0000000001000,
      S_BCHK   = 13'b0000000010000,
      S_BDIV   = 13'b0000000100000,
      S_BUPD   = 13'b0000001000000,
      S_BSWP   = 13'b0000010000000,
      S_BDINIT = 13'b0000100000000,
      S_BD     = 13'b0001000000000,
      S_BEND   = 13'b0010000000000,
      S_CHIEN  = 13'b0100000000000,
      S_CUPD   = 13'b1000000000000
   } fsm_type;

   fsm_type     state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        done_ff, done_in;
   logic [RspTdataBits-1:0] rsp_data_ff, rsp_data_in;

   logic        cmd_ff, cmd_in;
   logic [63:0] data_ff, data_in;
   logic [27:0] ecc_ff, ecc_in;
   logic [27:0] par_ff, par_in;
   logic [6:0]  cnt_ff, cnt_in;
   gf_type      syn_ff[8], syn_in[8];
   gf_type      exp_ff[4], exp_in[4];
   gf_type      elp_ff[16], elp_in[16];
   gf_type      pelp_ff[16], pelp_in[16];
   gf_type      cpy_ff[16], cpy_in[16];
   gf_type      t_ff[4], t_in[4];
   gf_type      loc_ff[4], loc_in[4];
   logic [3:0]  edeg_ff, edeg_in;
   logic [3:0]  pdeg_ff, pdeg_in;
   logic [3:0]  nd_ff, nd_in;
   logic [3:0]  j_ff, j_in;
   logic [2:0]  ppp_ff, ppp_in;
   logic [2:0]  bi_ff, bi_in;
   logic [2:0]  nroots_ff, nroots_in;
   gf_type      d_ff, d_in;
   gf_type      pd_ff, pd_in;
   gf_type      f_ff, f_in;
   logic        clean_ff, clean_in;
   logic        bad_ff, bad_in;

   gf_req_type  gf_req;
   gf_type      gf_res;
   logic [3:0]  sh;
   logic [3:0]  two_i2;
   logic [3:0]  eidx;
   logic [3:0]  sdiff;
   logic [3:0]  jm1;
   logic [3:0]  cpy_deg;
   logic [27:0] diff;
   logic        fb;
   gf_type      acc;
   logic [63:0] fix;
   logic        range_bad;
   logic        dec_bad;
   logic [6:0]  floc;
   logic [63:0] data_res;
   logic [1:0]  status_res;
   logic [2:0]  count_res;

   bch_gf_unit u_gf (
      .req (gf_req),
      .res (gf_res)
   );

   assign req_tready = (state_ff == S_IDLE) && !done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // index helpers, parity difference and feedback, copy degree and locator sum
   always_comb begin
      sh     = {bi_ff, 1'b1} - {1'b0, ppp_ff};
      two_i2 = {bi_ff, 1'b0} + 4'd2;
      eidx   = j_ff + sh;
      sdiff  = two_i2 - j_ff;
      jm1    = j_ff - 4'd1;
      diff   = par_ff ^ ecc_ff;
      fb     = par_ff[27] ^ data_ff[cnt_ff[5:0]];
      cpy_deg = '0;
      for (int k = 0; k < 16; k++) if (cpy_ff[k] != 7'd0) cpy_deg = 4'(k);
      acc = elp_ff[0];
      for (int k = 0; k < 4; k++) if (4'(k + 1) <= edeg_ff) acc = acc ^ t_ff[k];
   end

   // operand select for the shared gf unit
   always_comb begin
      gf_req = '{op: GF_MUL, a: '0, b: '0};
      unique case (state_ff)
         S_SQR: begin
            gf_req.a = syn_ff[3'(j_ff[1:0])];
            gf_req.b = syn_ff[3'(j_ff[1:0])];
         end
         S_BDIV: begin
            gf_req.op = GF_DIV;
            gf_req.a  = d_ff;
            gf_req.b  = pd_ff;
         end
         S_BUPD: begin
            gf_req.a = f_ff;
            gf_req.b = pelp_ff[j_ff];
         end
         S_BD: begin
            gf_req.a = elp_ff[j_ff];
            gf_req.b = syn_ff[sdiff[2:0]];
         end
         S_CUPD: begin
            gf_req.a = t_ff[jm1[1:0]];
            gf_req.b = GF_ALOG[7'd127 - {3'b000, j_ff}];
         end
         default: gf_req = '{op: GF_MUL, a: '0, b: '0};
      endcase
   end

   // correction mask and final result
   always_comb begin
      fix       = '0;
      range_bad = 1'b0;
      for (int k = 0; k < 4; k++) begin
         floc = loc_ff[k] - 7'd28;
         if (3'(k) < nroots_ff) begin
            if (loc_ff[k] >= 7'd92) range_bad = 1'b1;
            else if (loc_ff[k] >= 7'd28) fix = fix | (64'd1 << floc[5:0]);
         end
      end
      dec_bad = bad_ff || ({1'b0, nroots_ff} != edeg_ff) || range_bad;
      if (clean_ff) begin
         data_res   = data_ff;
         status_res = STATUS_CLEAN;
         count_res  = 3'd0;
      end else if (dec_bad) begin
         data_res   = data_ff;
         status_res = STATUS_UNCORR;
         count_res  = 3'd0;
      end else begin
         data_res   = data_ff ^ fix;
         status_res = STATUS_FIXED;
         count_res  = edeg_ff[2:0];
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      cmd_in    = cmd_ff;
      data_in   = data_ff;
      ecc_in    = ecc_ff;
      par_in    = par_ff;
      cnt_in    = cnt_ff;
      syn_in    = syn_ff;
      exp_in    = exp_ff;
      elp_in    = elp_ff;
      pelp_in   = pelp_ff;
      cpy_in    = cpy_ff;
      t_in      = t_ff;
      loc_in    = loc_ff;
      edeg_in   = edeg_ff;
      pdeg_in   = pdeg_ff;
      nd_in     = nd_ff;
      j_in      = j_ff;
      ppp_in    = ppp_ff;
      bi_in     = bi_ff;
      nroots_in = nroots_ff;
      d_in      = d_ff;
      pd_in     = pd_ff;
      f_in      = f_ff;
      clean_in  = clean_ff;
      bad_in    = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (done_ff) begin
               // hand the result over once the output slot is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {7'd0, count_res, status_res, par_ff, data_res};
                  done_in      = 1'b0;
               end
            end else if (req_tvalid) begin
               cmd_in   = req_tuser;
               data_in  = req_tdata[63:0];
               ecc_in   = req_tdata[91:64];
               par_in   = '0;
               cnt_in   = 7'd63;
               clean_in = 1'b0;
               bad_in   = 1'b0;
               for (int k = 0; k < 8; k++) syn_in[k] = '0;
               for (int k = 0; k < 4; k++) exp_in[k] = '0;
               state_in = S_LFSR;
            end
         end
         S_LFSR: begin
            // one data bit per cycle, most significant first
            par_in = {par_ff[26:0], 1'b0} ^ (fb ? GEN_TAPS : 28'd0);
            if (cnt_ff == 7'd0) begin
               if (cmd_ff == CMD_ENCODE || par_in == ecc_ff) begin
                  clean_in = 1'b1;
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SYN;
               end
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         S_SYN: begin
            // odd syndromes from one parity difference bit per cycle
            for (int k = 0; k < 4; k++) begin
               if (diff[cnt_ff[4:0]]) syn_in[2 * k] = syn_ff[2 * k] ^ GF_ALOG[exp_ff[k]];
               exp_in[k] = gf_mod({1'b0, exp_ff[k]} + 8'(2 * k + 1));
            end
            if (cnt_ff == 7'd27) begin
               j_in     = '0;
               state_in = S_SQR;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_SQR: begin
            // even syndromes by squaring
            syn_in[{j_ff[1:0], 1'b1}] = gf_res;
            if (j_ff == 4'd3) begin
               for (int k = 0; k < 16; k++) begin
                  elp_in[k]  = '0;
                  pelp_in[k] = '0;
               end
               elp_in[0]  = 7'd1;
               pelp_in[0] = 7'd1;
               edeg_in    = '0;
               pdeg_in    = '0;
               pd_in      = 7'd1;
               ppp_in     = '0;
               bi_in      = '0;
               d_in       = syn_ff[0];
               state_in   = S_BCHK;
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         S_BCHK: begin
            if (bi_ff == 3'd4 || edeg_ff > 4'd4) state_in = S_BEND;
            else if (d_ff != 7'd0) state_in = S_BDIV;
            else state_in = S_BDINIT;
         end
         S_BDIV: begin
            f_in     = gf_res;
            cpy_in   = elp_ff;
            nd_in    = pdeg_ff + sh;
            j_in     = '0;
            state_in = S_BUPD;
         end
         S_BUPD: begin
            // add the shifted previous locator, one coefficient a cycle
            elp_in[eidx] = elp_ff[eidx] ^ gf_res;
            if (j_ff == pdeg_ff) state_in = S_BSWP;
            else j_in = j_ff + 4'd1;
         end
         S_BSWP: begin
            if (nd_ff > edeg_ff) begin
               edeg_in = nd_ff;
               pelp_in = cpy_ff;
               pdeg_in = cpy_deg;
               pd_in   = d_ff;
               ppp_in  = {bi_ff[1:0], 1'b1};
            end
            state_in = S_BDINIT;
         end
         S_BDINIT: begin
            if (bi_ff == 3'd3) begin
               state_in = S_BEND;
            end else begin
               d_in     = syn_ff[two_i2[2:0]];
               j_in     = 4'd1;
               state_in = S_BD;
            end
         end
         S_BD: begin
            // next discrepancy, one product a cycle
            if (j_ff <= edeg_ff && j_ff <= two_i2) begin
               d_in = d_ff ^ gf_res;
               j_in = j_ff + 4'd1;
            end else begin
               bi_in    = bi_ff + 3'd1;
               state_in = S_BCHK;
            end
         end
         S_BEND: begin
            if (edeg_ff == 4'd0 || edeg_ff > 4'd4) begin
               bad_in   = 1'b1;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               for (int k = 0; k < 4; k++) t_in[k] = elp_ff[k + 1];
               cnt_in    = '0;
               nroots_in = '0;
               state_in  = S_CHIEN;
            end
         end
         S_CHIEN: begin
            // locator evaluated at alpha^-cnt
            if (acc == 7'd0) begin
               if (nroots_ff < 3'd4) loc_in[nroots_ff[1:0]] = cnt_ff;
               if (nroots_ff != 3'd7) nroots_in = nroots_ff + 3'd1;
            end
            j_in     = 4'd1;
            state_in = S_CUPD;
         end
         S_CUPD: begin
            // step each term by alpha^-j
            t_in[jm1[1:0]] = gf_res;
            if (j_ff == edeg_ff) begin
               if (cnt_ff == 7'd126) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 7'd1;
                  state_in = S_CHIEN;
               end
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff      <= cmd_in;
      data_ff     <= data_in;
      ecc_ff      <= ecc_in;
      par_ff      <= par_in;
      cnt_ff      <= cnt_in;
      syn_ff      <= syn_in;
      exp_ff      <= exp_in;
      elp_ff      <= elp_in;
      pelp_ff     <= pelp_in;
      cpy_ff      <= cpy_in;
      t_ff        <= t_in;
      loc_ff      <= loc_in;
      edeg_ff     <= edeg_in;
      pdeg_ff     <= pdeg_in;
      nd_ff       <= nd_in;
      j_ff        <= j_in;
      ppp_ff      <= ppp_in;
      bi_ff       <= bi_in;
      nroots_ff   <= nroots_in;
      d_ff        <= d_in;
      pd_ff       <= pd_in;
      f_ff        <= f_in;
      clean_ff    <= clean_in;
      bad_ff      <= bad_in;
   end

   `BCH_ASSERT_NEXT(a_accept_starts_parity, clock, reset, req_tvalid && req_tready, state_ff == S_LFSR, "accepted request did not start the parity pass")
   `BCH_ASSERT_NOW(a_search_degree, clock, reset, state_ff == S_CHIEN || state_ff == S_CUPD, edeg_ff != 4'd0 && edeg_ff <= 4'd4, "root search with locator degree out of range")
   `BCH_ASSERT_NOW(a_prev_degree, clock, reset, state_ff == S_BUPD, pdeg_ff <= 4'd4 && j_ff <= pdeg_ff, "previous locator degree out of range")
   `BCH_ASSERT_NOW(a_fixed_count, clock, reset, rsp_valid_ff && rsp_data_ff[93:92] == STATUS_FIXED, rsp_data_ff[96:94] != 3'd0 && rsp_data_ff[96:94] <= 3'd4, "corrected result with bad error count")

endmodule
